>>> sv/lfu_cache_table_defines.svh
// Assertion macros for the LFU cache table.
// Included by the top level; no other dependencies.
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

`define LFU_ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lfu_cache_table: check failed");

`define LFU_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lfu_cache_table: check failed");

`endif

>>> sv/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// Used by lfu_cell and lfu_cache_table; no dependencies.
package lfu_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int USE_W   = 32;
  localparam int STAMP_W = 48;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_BUMP,
    WB_UPDATE,
    WB_INSERT
  } wb_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic               active;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [VAL_W-1:0]   hit_value;
    logic               victim_valid;
    logic [USE_W-1:0]   victim_count;
    logic [STAMP_W-1:0] victim_last;
    logic [KEY_W-1:0]   victim_key;
    logic               free_valid;
  } probe_t;

  typedef struct packed {
    wb_op_t             op;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
  } wb_t;

endpackage

>>> sv/lfu_cell.sv
// One table entry of the LFU cache: holds its entry and folds it into the
// passing probe. Depends on lfu_pkg.
module lfu_cell import lfu_pkg::*; #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  probe_t           probe_in,
  input  logic [IDX_W-1:0] hit_idx_in,
  input  logic [IDX_W-1:0] victim_idx_in,
  input  logic [IDX_W-1:0] free_idx_in,
  input  logic [CNT_W-1:0] fill_in,
  output probe_t           probe_out,
  output logic [IDX_W-1:0] hit_idx_out,
  output logic [IDX_W-1:0] victim_idx_out,
  output logic [IDX_W-1:0] free_idx_out,
  output logic [CNT_W-1:0] fill_out,
  input  wb_t              wb,
  input  logic             wb_sel
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   value;
  logic [USE_W-1:0]   use_count;
  logic [STAMP_W-1:0] last_use;

  probe_t             probe_next;
  logic [IDX_W-1:0]   hit_idx_next;
  logic [IDX_W-1:0]   victim_idx_next;
  logic [IDX_W-1:0]   free_idx_next;
  logic [CNT_W-1:0]   fill_next;

  always_comb begin
    probe_next      = probe_in;
    hit_idx_next    = hit_idx_in;
    victim_idx_next = victim_idx_in;
    free_idx_next   = free_idx_in;
    fill_next       = fill_in;
    if (valid) begin
      fill_next = fill_in + CNT_W'(1);
      if (!probe_in.hit && key == probe_in.key) begin
        probe_next.hit       = 1'b1;
        probe_next.hit_value = value;
        hit_idx_next         = MY_IDX;
      end
      if (!probe_in.victim_valid || use_count < probe_in.victim_count ||
          (use_count == probe_in.victim_count && last_use < probe_in.victim_last)) begin
        probe_next.victim_valid = 1'b1;
        probe_next.victim_count = use_count;
        probe_next.victim_last  = last_use;
        probe_next.victim_key   = key;
        victim_idx_next         = MY_IDX;
      end
    end else if (!probe_in.free_valid) begin
      probe_next.free_valid = 1'b1;
      free_idx_next         = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
    hit_idx_out    <= hit_idx_next;
    victim_idx_out <= victim_idx_next;
    free_idx_out   <= free_idx_next;
    fill_out       <= fill_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wb_sel) begin
      case (wb.op)
        WB_BUMP: begin
          if (use_count != {USE_W{1'b1}}) use_count <= use_count + USE_W'(1);
          last_use <= wb.stamp;
        end
        WB_UPDATE: begin
          value <= wb.value;
          if (use_count != {USE_W{1'b1}}) use_count <= use_count + USE_W'(1);
          last_use <= wb.stamp;
        end
        WB_INSERT: begin
          valid     <= 1'b1;
          key       <= wb.key;
          value     <= wb.value;
          use_count <= '0;
          last_use  <= wb.stamp;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> sv/lfu_cache_table.sv
// Fully associative key-value table with least-frequently-used replacement.
// Depends on lfu_pkg, lfu_cell and lfu_cache_table_defines.svh.
//
// A request is taken when start is high and busy is low. It travels down a
// row of ENTRIES cells, one cell per cycle, gathering hit, victim and free
// slot; the scan state then decides from the last cell's probe, and done
// strobes the result for a single cycle while the chosen cell is written.
// busy drops in the done cycle, so the next request can start there. The
// receiver cannot stall: results must be taken the cycle done is high.
`include "lfu_cache_table_defines.svh"

module lfu_cache_table import lfu_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] put_value,
  output logic                    done,
  output logic                    found,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted,
  output logic signed [KEY_W-1:0] evicted_key,
  input  logic                    cfg_wr_en,
  input  logic [CAP_W-1:0]        cfg_wr_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t state, state_next;

  logic [CAP_W-1:0]   cap;
  logic [STAMP_W-1:0] use_clock;
  logic               req_kind;
  logic [VAL_W-1:0]   req_value;

  probe_t           probe  [0:ENTRIES];
  logic [IDX_W-1:0] hit_idx    [0:ENTRIES];
  logic [IDX_W-1:0] victim_idx [0:ENTRIES];
  logic [IDX_W-1:0] free_idx   [0:ENTRIES];
  logic [CNT_W-1:0] fill       [0:ENTRIES];

  wb_t               wb, wb_next;
  logic [ENTRIES-1:0] wb_sel, wb_sel_next;

  logic             accept;
  logic             decide;
  probe_t           head_next;
  probe_t           fin;
  logic [CMP_W-1:0] cap_ext, cap_eff, fill_ext;
  logic             evict_now;
  logic             found_next, evicted_next;
  logic [VAL_W-1:0] read_next;
  logic [KEY_W-1:0] ekey_next;

  assign accept = start && !busy;
  assign busy   = (state == ST_SCAN);
  assign done   = (state == ST_REPLY);
  assign fin    = probe[ENTRIES];
  assign decide = (state == ST_SCAN) && fin.active;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SCAN;
      ST_SCAN:  if (decide) state_next = ST_REPLY;
      ST_REPLY: state_next = accept ? ST_SCAN : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_next = '0;
    if (accept) begin
      head_next.active = 1'b1;
      head_next.key    = lookup_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe[0] <= '0;
    end else begin
      probe[0] <= head_next;
    end
    hit_idx[0]    <= '0;
    victim_idx[0] <= '0;
    free_idx[0]   <= '0;
    fill[0]       <= '0;
    if (accept) begin
      req_kind  <= kind;
      req_value <= put_value;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .probe_in       (probe[i]),
      .hit_idx_in     (hit_idx[i]),
      .victim_idx_in  (victim_idx[i]),
      .free_idx_in    (free_idx[i]),
      .fill_in        (fill[i]),
      .probe_out      (probe[i+1]),
      .hit_idx_out    (hit_idx[i+1]),
      .victim_idx_out (victim_idx[i+1]),
      .free_idx_out   (free_idx[i+1]),
      .fill_out       (fill[i+1]),
      .wb             (wb),
      .wb_sel         (wb_sel[i] && done)
    );
  end

  assign cap_ext  = CMP_W'(cap);
  assign cap_eff  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign fill_ext = CMP_W'(fill[ENTRIES]);
  assign evict_now = (fill_ext >= cap_eff) && fin.victim_valid;

  always_comb begin
    wb_next       = '0;
    wb_next.op    = WB_NONE;
    wb_next.key   = fin.key;
    wb_next.value = req_value;
    wb_next.stamp = use_clock + STAMP_W'(1);
    wb_sel_next   = '0;
    found_next    = fin.hit;
    read_next     = {VAL_W{1'b1}};
    evicted_next  = 1'b0;
    ekey_next     = '0;
    if (!req_kind) begin
      if (fin.hit) begin
        read_next   = fin.hit_value;
        wb_next.op  = WB_BUMP;
        wb_sel_next[hit_idx[ENTRIES]] = 1'b1;
      end
    end else if (cap_eff != '0) begin
      if (fin.hit) begin
        wb_next.op = WB_UPDATE;
        wb_sel_next[hit_idx[ENTRIES]] = 1'b1;
      end else if (evict_now) begin
        evicted_next = 1'b1;
        ekey_next    = fin.victim_key;
        wb_next.op   = WB_INSERT;
        wb_sel_next[victim_idx[ENTRIES]] = 1'b1;
      end else if (fin.free_valid) begin
        wb_next.op = WB_INSERT;
        wb_sel_next[free_idx[ENTRIES]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock <= '0;
    end else if (decide && wb_next.op != WB_NONE) begin
      use_clock <= wb_next.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      wb          <= wb_next;
      wb_sel      <= wb_sel_next;
      found       <= found_next;
      read_value  <= read_next;
      evicted     <= evicted_next;
      evicted_key <= ekey_next;
    end
  end

  `LFU_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `LFU_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy)
  `LFU_ASSERT_SAME(a_evict_miss, clk, rst, done && evicted, !found)
  `LFU_ASSERT_SAME(a_miss_value, clk, rst, done && !found, read_value == -1)

endmodule

>>> tb/sv/lfu_cache_table_tb.sv
// Self-checking bench for lfu_cache_table: get/put requests with LFU eviction.
// Predicts each response with an in-bench LFU table; depends on lfu_pkg and the RTL.
module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int NSLOT = 16;
  localparam int LIMIT = 1200000;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } response_t;

  logic clk, rst, start, kind, cfg_wr_en, done, found, evicted, busy;
  logic signed [KEY_W-1:0] lookup_key, evicted_key;
  logic signed [VAL_W-1:0] put_value, read_value;
  logic [CAP_W-1:0] cfg_wr_data;

  request_t pending_reqs[$];
  response_t expected_resps[$];
  int errors;
  int cycles;
  bit quiet;

  logic [CAP_W-1:0] cap_reg;
  logic slot_valid[NSLOT];
  logic [KEY_W-1:0] slot_key[NSLOT];
  logic [VAL_W-1:0] slot_value[NSLOT];
  logic [USE_W-1:0] slot_count[NSLOT];
  logic [STAMP_W-1:0] slot_last[NSLOT];
  logic [STAMP_W-1:0] use_clk;

  lfu_cache_table u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .lookup_key(lookup_key), .put_value(put_value), .done(done), .found(found),
    .read_value(read_value), .evicted(evicted), .evicted_key(evicted_key),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void touch_slot(int i);
    if (slot_count[i] != '1) slot_count[i] = slot_count[i] + 1;
    use_clk = use_clk + 1;
    slot_last[i] = use_clk;
  endfunction

  function automatic response_t lfu_predict(request_t r);
    response_t res;
    int hit, free_slot, victim, fill, cap, slot;
    hit = -1;
    free_slot = -1;
    victim = -1;
    fill = 0;
    res = '{1'b0, '1, 1'b0, '0};
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_valid[i]) begin
        fill++;
        if (hit < 0 && slot_key[i] == r.key) hit = i;
        if (victim < 0 || slot_count[i] < slot_count[victim] ||
            (slot_count[i] == slot_count[victim] && slot_last[i] < slot_last[victim]))
          victim = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    cap = (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
    res.found = (hit >= 0);
    if (!r.kind) begin
      if (hit >= 0) begin
        res.read_value = slot_value[hit];
        touch_slot(hit);
      end
    end else if (cap != 0) begin
      if (hit >= 0) begin
        slot_value[hit] = r.value;
        touch_slot(hit);
      end else begin
        slot = free_slot;
        if (fill >= cap && victim >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = slot_key[victim];
          slot = victim;
        end
        if (slot >= 0) begin
          slot_valid[slot] = 1'b1;
          slot_key[slot] = r.key;
          slot_value[slot] = r.value;
          slot_count[slot] = '0;
          use_clk = use_clk + 1;
          slot_last[slot] = use_clk;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {1'b1, 31'($urandom_range(0, 20))};
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  task automatic queue_req(logic k, logic [KEY_W-1:0] key, logic [VAL_W-1:0] v);
    pending_reqs.push_back('{k, key, v});
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_cap(logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cap_reg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_resps.push_back(lfu_predict('{kind, lookup_key, put_value}));
      if (pending_reqs.size() != 0 && !quiet && ($urandom_range(0, 99) >= 17 || cycles < 8000))
      begin
        {kind, lookup_key, put_value} <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_reqs.size() != 0 && !quiet &&
                 ($urandom_range(0, 99) >= 17 || cycles < 8000)) begin
      {kind, lookup_key, put_value} <= pending_reqs.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    response_t exp_r;
    if (!rst && done) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected response found=%b read=%h", $time, found, read_value);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (found !== exp_r.found || read_value !== exp_r.read_value ||
            evicted !== exp_r.evicted || evicted_key !== exp_r.evicted_key) begin
          $display("%0t: mismatch expected %b %h %b %h actual %b %h %b %h", $time,
                   exp_r.found, exp_r.read_value, exp_r.evicted, exp_r.evicted_key,
                   found, read_value, evicted, evicted_key);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] caps[6];
    int n;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd17};
    rst = 1'b1;
    start = 1'b0;
    kind = 1'b0;
    lookup_key = '0;
    put_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    cap_reg = CAP_RESET;
    use_clk = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_count[i] = '0;
      slot_last[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    queue_req(1'b0, 32'h8000_0000, '0);
    queue_req(1'b1, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(1'b1, 32'h7fff_ffff, 32'h8000_0000);
    queue_req(1'b1, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(1'b0, 32'h8000_0000, 32'h1234_5678);
    queue_req(1'b0, 32'h7fff_ffff, '0);
    queue_req(1'b1, 32'h7fff_ffff, 32'h0);
    for (int i = 0; i < 14; i++) queue_req(1'b1, i, i * 3);
    queue_req(1'b1, 32'd100, 32'd5);
    queue_req(1'b0, 32'd100, '0);
    queue_req(1'b0, 32'hffff_ffff, '0);
    drain();
    for (int p = 0; p < 6; p++) begin
      write_cap(caps[p]);
      if (p == 3) begin
        quiet = 1'b1;
        drain();
        quiet = 1'b0;
      end
      n = (p == 0) ? 500 : 230;
      for (int j = 0; j < n; j++) queue_req($urandom_range(0, 1), pick_key(), $urandom());
      drain();
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> lfu_cache_table.f
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_cell.sv
sv/lfu_cache_table.sv
tb/sv/lfu_cache_table_tb.sv
